// File: src/mres_pkg.sv
// shared types, constants and controller codes for the max repeated element select block
package mres_pkg;

   localparam int MAX_ELEMENTS_DEFAULT = 256;
   localparam int DATA_WIDTH           = 32;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         is_last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] max_repeated;
      logic                         found;
      logic                         overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_IREAD,
      ST_IWAIT,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic search_start;
      logic rd_sel_i;
      logic latch_vi;
      logic i_inc;
      logic j_init;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic i_lt_n;
      logic skip;
      logic hit;
      logic scan_done;
      logic rsp_free;
   } status_type;

endpackage

// File: src/max_repeated_element_select.sv
// top level of the max repeated element select block
// Collects a set of signed 32-bit requests, one per cycle while req_stall is
// low, into an element store of MAX_ELEMENTS entries; the request with
// is_last set closes the set. Requests beyond capacity are dropped and
// reported through overflow. After the last request the block runs a
// pairwise search over the stored elements through the single read port of
// the store and stalls requests meanwhile: an outer element that cannot beat
// the current best is skipped, otherwise it is compared with each later
// element until a match ends the scan or the later elements run out. When
// the search ends, the result is posted once the output register is free.
// The result is the largest value seen at least twice (found set), or 0
// with found cleared. The result sits in an output register, so loading of
// the next set proceeds while it waits.
module max_repeated_element_select #(
   parameter int MAX_ELEMENTS = mres_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mres_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mres_pkg::rsp_type rsp_data
);

   // command and status between sequencer and datapath
   mres_pkg::cmd_type    cmd;
   mres_pkg::status_type status;

   // sequencer: owns the request stall and the search order
   mres_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.is_last),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: store, counters, compare and result register
   mres_dp #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: src/mres_ram.sv
// generic single write port ram with registered read
module mres_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/mres_ctrl.sv
// sequencing state machine: load, pairwise search, result handoff
module mres_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_stall,
   input  mres_pkg::status_type status,
   output mres_pkg::cmd_type    cmd
);

   mres_pkg::state_type state_ff;
   mres_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mres_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mres_pkg::ST_LOAD: begin
            if (req_valid && req_last) state_in = mres_pkg::ST_IREAD;
         end
         mres_pkg::ST_IREAD: begin
            state_in = status.i_lt_n ? mres_pkg::ST_IWAIT : mres_pkg::ST_FINISH;
         end
         mres_pkg::ST_IWAIT: begin
            state_in = status.skip ? mres_pkg::ST_IREAD : mres_pkg::ST_SCAN;
         end
         mres_pkg::ST_SCAN: begin
            if (status.hit || status.scan_done) state_in = mres_pkg::ST_IREAD;
         end
         mres_pkg::ST_FINISH: begin
            if (status.rsp_free) state_in = mres_pkg::ST_LOAD;
         end
         default: state_in = mres_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         mres_pkg::ST_LOAD: begin
            req_stall        = 1'b0;
            cmd.accept       = req_valid;
            cmd.search_start = req_valid && req_last;
         end
         mres_pkg::ST_IREAD: begin
            cmd.rd_sel_i = 1'b1;
         end
         mres_pkg::ST_IWAIT: begin
            cmd.latch_vi = 1'b1;
            cmd.i_inc    = status.skip;
            cmd.j_init   = !status.skip;
         end
         mres_pkg::ST_SCAN: begin
            cmd.scan  = 1'b1;
            cmd.i_inc = status.hit || status.scan_done;
         end
         mres_pkg::ST_FINISH: begin
            cmd.finish = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: src/mres_dp.sv
// datapath: element store, search counters, best tracking and result register
module mres_dp #(
   parameter int MAX_ELEMENTS = mres_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mres_pkg::req_type    req_data,
   input  mres_pkg::cmd_type    cmd,
   output mres_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mres_pkg::rsp_type    rsp_data
);

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int DW = mres_pkg::DATA_WIDTH;

   logic [CW-1:0]        fill_count_ff, fill_count_in;
   logic                 overflow_ff, overflow_in;
   logic [CW-1:0]        i_ff, i_in;
   logic [CW-1:0]        j_ff, j_in;
   logic [DW-1:0]        vi_ff, vi_in;
   logic signed [DW-1:0] best_ff, best_in;
   logic                 any_ff, any_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mres_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic          full;
   logic          wr_en;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [DW-1:0] rd_data;
   logic          issue_ok;

   assign full     = (fill_count_ff == CW'(MAX_ELEMENTS));
   assign wr_en    = cmd.accept && !full;
   assign rd_en    = cmd.rd_sel_i || cmd.scan;
   assign rd_addr  = cmd.rd_sel_i ? i_ff[AW-1:0] : j_ff[AW-1:0];
   assign issue_ok = (j_ff < fill_count_ff);

   mres_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_count_ff[AW-1:0]),
      .wr_data (DW'(unsigned'(req_data.value))),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      status.i_lt_n    = (i_ff < fill_count_ff);
      status.skip      = any_ff && ($signed(rd_data) <= best_ff);
      status.hit       = cmp_valid_ff && (rd_data == vi_ff);
      status.scan_done = !issue_ok && !cmp_valid_ff;
      status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      fill_count_in = fill_count_ff;
      overflow_in   = overflow_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      vi_in         = vi_ff;
      best_in       = best_ff;
      any_in        = any_ff;
      cmp_valid_in  = cmp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.accept) begin
         if (full) overflow_in = 1'b1;
         else      fill_count_in = fill_count_ff + CW'(1);
      end
      if (cmd.search_start) begin
         i_in    = '0;
         any_in  = 1'b0;
         best_in = '0;
      end
      if (cmd.latch_vi) begin
         vi_in        = rd_data;
         cmp_valid_in = 1'b0;
      end
      if (cmd.j_init) begin
         j_in = i_ff + CW'(1);
      end
      if (cmd.scan) begin
         cmp_valid_in = issue_ok && !status.hit;
         if (issue_ok && !status.hit) j_in = j_ff + CW'(1);
         // pair found: this value beats the current best, if there is one
         if (status.hit) begin
            best_in = $signed(vi_ff);
            any_in  = 1'b1;
         end
      end
      if (cmd.i_inc) begin
         i_in = i_ff + CW'(1);
      end
      if (cmd.finish) begin
         rsp_data_in.max_repeated = any_ff ? best_ff : '0;
         rsp_data_in.found        = any_ff;
         rsp_data_in.overflow     = overflow_ff;
         rsp_valid_in             = 1'b1;
         fill_count_in            = '0;
         overflow_in              = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         overflow_ff   <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         any_ff        <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         overflow_ff   <= overflow_in;
         cmp_valid_ff  <= cmp_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         any_ff        <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      vi_ff       <= vi_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && !full) |=> (fill_count_ff == $past(fill_count_ff) + CW'(1)))
      else $error("fill count did not advance on a stored request");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (fill_count_ff == '0) && !overflow_ff && rsp_valid_ff)
      else $error("finish did not clear the set and post the result");

   a_latch_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.latch_vi |-> (i_ff < fill_count_ff))
      else $error("search element index beyond stored count");

   a_no_repeat_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found) |-> (rsp_data_ff.max_repeated == '0))
      else $error("result without repeat carries a nonzero value");

endmodule
